### rtl/core/mpps_pkg.sv
// Package for the maglev PID plant step core: widths, command codes and
// the controller-to-datapath command and status structs. No dependencies.
package mpps_pkg;

    localparam int unsigned QW = 32;
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_SETPOINT = 3'd0;
    localparam logic [IDX_W-1:0] REG_BIAS     = 3'd1;
    localparam logic [IDX_W-1:0] REG_KP       = 3'd2;
    localparam logic [IDX_W-1:0] REG_KI       = 3'd3;
    localparam logic [IDX_W-1:0] REG_KD       = 3'd4;
    localparam logic [IDX_W-1:0] REG_DT       = 3'd5;
    localparam logic [IDX_W-1:0] REG_GRAVITY  = 3'd6;
    localparam logic [IDX_W-1:0] REG_FORCE    = 3'd7;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_TICK_PREP,
        OP_MUL_VDT,
        OP_MUL_ADT,
        OP_MUL_EDT,
        OP_TICK_COMMIT,
        OP_MUL_KP,
        OP_MUL_KI,
        OP_MUL_KD,
        OP_CURRENT,
        OP_MUL_CC,
        OP_MUL_SQF,
        OP_MUL_PP,
        OP_DEN,
        OP_ACC_DONE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic div_start;
        logic div_sel_acc;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic mul_busy;
    } dp_status_t;

endpackage

### rtl/core/mpps_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Widths come from the NW and DW parameters; no package is used.
module mpps_div #(
    parameter int unsigned NW = 64,
    parameter int unsigned DW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic                 busy,
    output logic signed [NW:0]   quo
);
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[DW-1:0], q_reg[NW-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = num[NW-1] ? NW'(-num) : NW'(num);
            d_next    = den[DW-1] ? DW'(-den) : DW'(den);
            r_next    = '0;
            neg_next  = num[NW-1] ^ den[DW-1];
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DW])
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DW-1:0], q_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign quo  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
endmodule

### rtl/core/mpps_datapath.sv
// Datapath: configuration and state registers, one shared registered
// multiplier and the shared divider. Depends on mpps_pkg and mpps_div.
module mpps_datapath #(
    parameter int unsigned FRAC_BITS     = 16,
    parameter int unsigned INIT_POSITION = 334234
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [mpps_pkg::IDX_W-1:0] cfg_idx,
    input  logic [mpps_pkg::QW-1:0]    cfg_data,
    input  mpps_pkg::dp_cmd_t          cmd,
    output mpps_pkg::dp_status_t       status,
    output logic [7*mpps_pkg::QW-1:0]  result
);
    localparam int unsigned W = mpps_pkg::QW;
    localparam logic signed [63:0] QMAX = 64'sd2147483647;
    localparam logic signed [63:0] QMIN = -64'sd2147483648;

    function automatic logic signed [W-1:0] sat(input logic signed [67:0] v);
        if (v > 68'(QMAX))
        begin
            return W'(QMAX);
        end
        else if (v < 68'(QMIN))
        begin
            return W'(QMIN);
        end
        return v[W-1:0];
    endfunction

    logic signed [W-1:0] sp_reg, bias_reg, kp_reg, ki_reg, kd_reg, g_reg;
    logic [W-2:0]        dt_reg, fc_reg;
    logic signed [W-1:0] pos_reg, vel_reg, acc_reg, err_reg;
    logic signed [W-1:0] integ_reg, deriv_reg, cur_reg;
    logic signed [W-1:0] errn_reg, posn_reg, veln_reg, num_reg, den_reg;
    logic signed [W:0]   ma_reg, mb_reg;
    logic signed [67:0]  sum_reg;
    logic signed [65:0]  prod_reg;
    logic                mvalid_reg;
    logic signed [63:0]  qm;
    logic signed [W-1:0] mul_sat;
    logic signed [63:0]  diff;
    logic signed [63:0]  dnum;
    logic signed [W-1:0] dden;
    logic                div_busy;
    logic signed [64:0]  quo;

    assign qm      = 64'(prod_reg >>> FRAC_BITS);
    assign mul_sat = sat(68'(qm));
    assign diff    = 64'(errn_reg) - 64'(err_reg);
    assign dnum    = cmd.div_sel_acc ? (64'(num_reg) <<< FRAC_BITS)
                                     : (diff <<< FRAC_BITS);
    assign dden    = cmd.div_sel_acc ? den_reg : $signed({1'b0, dt_reg});

    mpps_div #(.NW(64), .DW(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (dnum),
        .den   (dden),
        .busy  (div_busy),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0; bias_reg <= '0; kp_reg <= '0; ki_reg <= '0;
            kd_reg <= '0; dt_reg <= (W-1)'(655); g_reg <= W'(642253);
            fc_reg <= '0;
            pos_reg <= '0; vel_reg <= '0; acc_reg <= '0; err_reg <= '0;
            integ_reg <= '0; deriv_reg <= '0; cur_reg <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    mpps_pkg::REG_SETPOINT: sp_reg   <= cfg_data;
                    mpps_pkg::REG_BIAS:     bias_reg <= cfg_data;
                    mpps_pkg::REG_KP:       kp_reg   <= cfg_data;
                    mpps_pkg::REG_KI:       ki_reg   <= cfg_data;
                    mpps_pkg::REG_KD:       kd_reg   <= cfg_data;
                    mpps_pkg::REG_DT:       dt_reg   <= cfg_data[W-2:0];
                    mpps_pkg::REG_GRAVITY:  g_reg    <= cfg_data;
                    mpps_pkg::REG_FORCE:    fc_reg   <= cfg_data[W-2:0];
                    default: ;
                endcase
            end
            mvalid_reg <= 1'b0;
            case (cmd.op)
                mpps_pkg::OP_INIT:
                begin
                    pos_reg   <= W'(INIT_POSITION);
                    vel_reg   <= '0;
                    integ_reg <= '0;
                    deriv_reg <= '0;
                    err_reg   <= sat(68'(sp_reg) - 68'(INIT_POSITION));
                    sum_reg   <= '0;
                end
                mpps_pkg::OP_TICK_PREP:
                begin
                    errn_reg <= sat(68'(sp_reg) - 68'(pos_reg));
                    sum_reg  <= '0;
                end
                mpps_pkg::OP_MUL_VDT:
                begin
                    ma_reg <= 33'(vel_reg); mb_reg <= $signed({2'b0, dt_reg});
                    mvalid_reg <= 1'b1;
                end
                mpps_pkg::OP_MUL_ADT:
                begin
                    posn_reg <= sat(68'(pos_reg) + 68'(qm));
                    ma_reg <= 33'(acc_reg); mb_reg <= $signed({2'b0, dt_reg});
                    mvalid_reg <= 1'b1;
                end
                mpps_pkg::OP_MUL_EDT:
                begin
                    veln_reg <= sat(68'(vel_reg) + 68'(qm));
                    ma_reg <= 33'(err_reg); mb_reg <= $signed({2'b0, dt_reg});
                    mvalid_reg <= 1'b1;
                end
                mpps_pkg::OP_TICK_COMMIT:
                begin
                    integ_reg <= sat(68'(integ_reg) + 68'(qm));
                    if (dt_reg == '0)
                    begin
                        deriv_reg <= (diff > 0) ? W'(QMAX)
                                   : ((diff < 0) ? W'(QMIN) : '0);
                    end
                    else
                    begin
                        deriv_reg <= sat(68'(quo));
                    end
                    err_reg   <= errn_reg;
                    vel_reg   <= veln_reg;
                    pos_reg   <= posn_reg;
                end
                mpps_pkg::OP_MUL_KP:
                begin
                    ma_reg <= 33'(err_reg); mb_reg <= 33'(kp_reg);
                    mvalid_reg <= 1'b1;
                end
                mpps_pkg::OP_MUL_KI:
                begin
                    sum_reg <= sum_reg + 68'(qm);
                    ma_reg <= 33'(integ_reg); mb_reg <= 33'(ki_reg);
                    mvalid_reg <= 1'b1;
                end
                mpps_pkg::OP_MUL_KD:
                begin
                    sum_reg <= sum_reg + 68'(qm);
                    ma_reg <= 33'(deriv_reg); mb_reg <= 33'(kd_reg);
                    mvalid_reg <= 1'b1;
                end
                mpps_pkg::OP_CURRENT:
                begin
                    cur_reg <= sat(68'(bias_reg) - (sum_reg + 68'(qm)));
                end
                mpps_pkg::OP_MUL_CC:
                begin
                    ma_reg <= 33'(cur_reg); mb_reg <= 33'(cur_reg);
                    mvalid_reg <= 1'b1;
                end
                mpps_pkg::OP_MUL_SQF:
                begin
                    ma_reg <= 33'(mul_sat); mb_reg <= $signed({2'b0, fc_reg});
                    mvalid_reg <= 1'b1;
                end
                mpps_pkg::OP_MUL_PP:
                begin
                    num_reg <= mul_sat;
                    ma_reg <= 33'(pos_reg); mb_reg <= 33'(pos_reg);
                    mvalid_reg <= 1'b1;
                end
                mpps_pkg::OP_DEN:
                begin
                    den_reg <= mul_sat;
                end
                mpps_pkg::OP_ACC_DONE:
                begin
                    if (den_reg == '0)
                    begin
                        acc_reg <= (num_reg != '0) ? W'(QMIN) : g_reg;
                    end
                    else
                    begin
                        acc_reg <= sat(68'(g_reg) - 68'(sat(68'(quo))));
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(ma_reg * mb_reg);
    end

    assign status.div_busy = div_busy;
    assign status.mul_busy = mvalid_reg;
    assign result = {deriv_reg, integ_reg, err_reg, acc_reg, vel_reg, pos_reg, cur_reg};
endmodule

### rtl/core/mpps_ctrl.sv
// Controller state machine sequencing multiplies and divisions for one
// item. Depends on mpps_pkg.
module mpps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 in_restart,
    input  logic                 out_free,
    input  mpps_pkg::dp_status_t status,
    output mpps_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_PREP, S_VDT, S_W1, S_ADT, S_W2, S_EDT, S_DSTART,
        S_DWAIT, S_COMMIT, S_KP, S_W3, S_KI, S_W4, S_KD, S_W5, S_CUR,
        S_CC, S_W6, S_SQF, S_W7, S_PP, S_W8, S_DEN, S_ADIV, S_AWAIT,
        S_ACC, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd.op          = mpps_pkg::OP_NONE;
        cmd.div_start   = 1'b0;
        cmd.div_sel_acc = 1'b0;
        case (state_reg)
            S_IDLE:   if (in_fire) state_next = in_restart ? S_INIT : S_PREP;
            S_INIT:   begin cmd.op = mpps_pkg::OP_INIT; state_next = S_KP; end
            S_PREP:   begin cmd.op = mpps_pkg::OP_TICK_PREP; state_next = S_VDT; end
            S_VDT:    begin cmd.op = mpps_pkg::OP_MUL_VDT; state_next = S_W1; end
            S_W1:     state_next = S_ADT;
            S_ADT:    begin cmd.op = mpps_pkg::OP_MUL_ADT; state_next = S_W2; end
            S_W2:     state_next = S_EDT;
            S_EDT:    begin cmd.op = mpps_pkg::OP_MUL_EDT; state_next = S_DSTART; end
            S_DSTART: begin cmd.div_start = 1'b1; state_next = S_DWAIT; end
            S_DWAIT:  if (!status.div_busy) state_next = S_COMMIT;
            S_COMMIT: begin cmd.op = mpps_pkg::OP_TICK_COMMIT; state_next = S_KP; end
            S_KP:     begin cmd.op = mpps_pkg::OP_MUL_KP; state_next = S_W3; end
            S_W3:     state_next = S_KI;
            S_KI:     begin cmd.op = mpps_pkg::OP_MUL_KI; state_next = S_W4; end
            S_W4:     state_next = S_KD;
            S_KD:     begin cmd.op = mpps_pkg::OP_MUL_KD; state_next = S_W5; end
            S_W5:     state_next = S_CUR;
            S_CUR:    begin cmd.op = mpps_pkg::OP_CURRENT; state_next = S_CC; end
            S_CC:     begin cmd.op = mpps_pkg::OP_MUL_CC; state_next = S_W6; end
            S_W6:     state_next = S_SQF;
            S_SQF:    begin cmd.op = mpps_pkg::OP_MUL_SQF; state_next = S_W7; end
            S_W7:     state_next = S_PP;
            S_PP:     begin cmd.op = mpps_pkg::OP_MUL_PP; state_next = S_W8; end
            S_W8:     state_next = S_DEN;
            S_DEN:    begin cmd.op = mpps_pkg::OP_DEN; state_next = S_ADIV; end
            S_ADIV:
            begin
                cmd.div_start = 1'b1; cmd.div_sel_acc = 1'b1; state_next = S_AWAIT;
            end
            S_AWAIT:  if (!status.div_busy) state_next = S_ACC;
            S_ACC:    begin cmd.op = mpps_pkg::OP_ACC_DONE; state_next = S_OUT; end
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT) && out_free;
endmodule

### rtl/core/maglev_pid_plant_step_core.sv
// Top level of the maglev PID plant step core: stream ports, output
// register, controller and datapath. Depends on mpps_pkg and submodules.
//
// Each item on the slave stream (restart in tdata bit 0) produces one item on
// the master stream. A tick item runs one Euler step of the PID-controlled
// levitation plant; a restart item instead resets position, velocity and the
// error terms, then computes current and acceleration. A restart needs one
// division on the shared bit-serial divider (one quotient bit per cycle) and a
// tick two; the remaining steps run on the shared registered multiplier. A new
// item is taken only in the cycle after the result has moved into the output
// register, so items never overlap, and a stalled master stream holds it off.
module maglev_pid_plant_step_core #(
    parameter int unsigned FRAC_BITS     = 16,
    parameter int unsigned INIT_POSITION = 334234
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // restart, zero fill
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [223:0] m_tdata,   // coil_current, position, velocity,
                                    // acceleration, error_value,
                                    // error_integral, error_derivative
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [31:0]  cfg_data
);
    mpps_pkg::dp_cmd_t    cmd;
    mpps_pkg::dp_status_t status;
    logic                 busy, done, out_free;
    logic [223:0]         result;
    logic                 mvalid_reg;
    logic [223:0]         mdata_reg;

    assign s_tready = !busy;
    assign out_free = !mvalid_reg || m_tready;

    mpps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (s_tvalid && s_tready),
        .in_restart (s_tdata[0]),
        .out_free   (out_free),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done)
    );

    mpps_datapath #(.FRAC_BITS(FRAC_BITS), .INIT_POSITION(INIT_POSITION)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvalid_reg <= 1'b0;
        end
        else if (done)
        begin
            mvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            mdata_reg <= result;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
endmodule
